// File: design/tswd_pkg.sv
package tswd_pkg;

	// transaction kinds on the request channel
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_INDEX = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} tswd_cmd_t;

	// register indexes
	localparam logic [7:0] IDX_VERSION = 8'h02;
	localparam logic [7:0] IDX_COUNT1  = 8'h0C;
	localparam logic [7:0] IDX_COUNT2  = 8'h0E;
	localparam logic [7:0] IDX_PULSE   = 8'h0F;
	localparam logic [7:0] IDX_CONTROL = 8'h10;
	localparam logic [7:0] IDX_STATUS  = 8'h12;

	// control word bits
	localparam int CTL_EN1   = 0;
	localparam int CTL_EN2   = 1;
	localparam int CTL_RST1  = 4;
	localparam int CTL_RST2  = 5;
	localparam int CTL_SCI   = 8;
	localparam int CTL_NMI   = 9;
	localparam int CTL_SMI   = 10;
	localparam int CTL_RESET = 11;

	// status bits
	localparam int ST_EXP1 = 0;
	localparam int ST_EXP2 = 1;

	localparam logic [15:0] VERSION_WORD = 16'hFFFF;

	// result of one transaction
	typedef struct packed {
		logic [15:0] rdata;
		logic        sys_reset_out;
		logic        smi_out;
		logic        nmi_out;
		logic        sci_out;
	} tswd_result_t;

endpackage

// File: design/tswd_if.sv
interface tswd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic        word_access;
	logic [15:0] wdata;

	modport source (output valid, cmd, word_access, wdata, input ready);
	modport sink   (input valid, cmd, word_access, wdata, output ready);
endinterface

interface tswd_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] rdata;
	logic        sys_reset_out;
	logic        smi_out;
	logic        nmi_out;
	logic        sci_out;

	modport source (output valid, rdata, sys_reset_out, smi_out, nmi_out, sci_out,
		input ready);
	modport sink   (input valid, rdata, sys_reset_out, smi_out, nmi_out, sci_out,
		output ready);
endinterface

// File: design/tswd_core.sv
module tswd_core
	import tswd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  logic [1:0]   cmd,
	input  logic         word_access,
	input  logic [15:0]  wdata,
	output tswd_result_t result
);

	logic [7:0]  reg_index_q,     reg_index_d;
	logic [15:0] control_q,       control_d;
	logic [7:0]  status_q,        status_d;
	logic [15:0] reload1_q,       reload1_d;
	logic [15:0] count1_q,        count1_d;
	logic [7:0]  reload2_q,       reload2_d;
	logic [7:0]  count2_q,        count2_d;
	logic        running2_q,      running2_d;
	logic [7:0]  pulse_length_q,  pulse_length_d;
	logic [7:0]  pulse_left_q,    pulse_left_d;

	tswd_cmd_t   cmd_e;
	logic        stage1_active;
	logic        stage2_active;
	logic [15:0] count1_dec;
	logic [7:0]  count2_dec;
	logic [15:0] merged;
	logic [15:0] ctl_rise;
	logic [15:0] read_word;
	logic        pulse_on;
	logic        as_reset;

	assign cmd_e = tswd_cmd_t'(cmd);

	// saturating decrements of the two counters
	assign count1_dec = (count1_q != 16'd0) ? count1_q - 16'd1 : 16'd0;
	assign count2_dec = (count2_q != 8'd0) ? count2_q - 8'd1 : 8'd0;
	assign stage1_active = control_q[CTL_EN1] && !running2_q;
	assign stage2_active = running2_q && (control_q[CTL_EN1] || control_q[CTL_EN2]);

	// byte port touches only the low byte of a 16-bit register
	always_comb begin
		merged = 16'd0;
		if (reg_index_q == IDX_COUNT1) begin
			merged = word_access ? wdata : {reload1_q[15:8], wdata[7:0]};
		end else begin
			merged = word_access ? wdata : {control_q[15:8], wdata[7:0]};
		end
	end
	assign ctl_rise = merged & ~control_q;

	// next state for one transaction
	always_comb begin
		reg_index_d    = reg_index_q;
		control_d      = control_q;
		status_d       = status_q;
		reload1_d      = reload1_q;
		count1_d       = count1_q;
		reload2_d      = reload2_q;
		count2_d       = count2_q;
		running2_d     = running2_q;
		pulse_length_d = pulse_length_q;
		pulse_left_d   = pulse_left_q;
		unique case (cmd_e)
			CMD_TICK: begin
				if (pulse_left_q != 8'd0) begin
					pulse_left_d = pulse_left_q - 8'd1;
				end
				if (stage1_active && count1_dec == 16'd0) begin
					status_d[ST_EXP2] = 1'b0;
					status_d[ST_EXP1] = 1'b1;
					count1_d          = reload1_q;
					count2_d          = reload2_q;
					running2_d        = 1'b1;
					pulse_left_d      = pulse_length_q;
				end else begin
					if (stage1_active) begin
						count1_d = count1_dec;
					end
					if (stage2_active) begin
						if (count2_dec == 8'd0) begin
							count2_d          = 8'd0;
							running2_d        = 1'b0;
							status_d[ST_EXP2] = 1'b1;
							pulse_left_d      = pulse_length_q;
						end else begin
							count2_d = count2_dec;
						end
					end
				end
			end
			CMD_INDEX: begin
				reg_index_d = wdata[7:0];
			end
			CMD_WRITE: begin
				unique case (reg_index_q)
					IDX_COUNT1: begin
						reload1_d = merged;
						count1_d  = merged;
					end
					IDX_COUNT2: begin
						reload2_d = wdata[7:0];
						count2_d  = wdata[7:0];
					end
					IDX_PULSE: begin
						pulse_length_d = wdata[7:0];
					end
					IDX_CONTROL: begin
						control_d = merged;
						if (ctl_rise[CTL_RST1]) begin
							count1_d   = reload1_q;
							running2_d = 1'b0;
						end
						if (ctl_rise[CTL_RST2]) begin
							count2_d = reload2_q;
						end
					end
					IDX_STATUS: begin
						status_d = wdata[7:0];
					end
					default: begin
					end
				endcase
			end
			CMD_READ: begin
			end
			default: begin
			end
		endcase
	end

	// register read mux
	always_comb begin
		unique case (reg_index_q)
			IDX_VERSION: read_word = VERSION_WORD;
			IDX_COUNT1:  read_word = count1_q;
			IDX_COUNT2:  read_word = {8'd0, count2_q};
			IDX_PULSE:   read_word = {8'd0, pulse_length_q};
			IDX_CONTROL: read_word = control_q;
			IDX_STATUS:  read_word = {8'd0, status_q};
			default:     read_word = 16'd0;
		endcase
	end

	// pulse outputs follow the state left by this transaction
	assign pulse_on = pulse_left_d != 8'd0;
	assign as_reset = status_d[ST_EXP2];

	always_comb begin
		result.rdata = 16'd0;
		if (cmd_e == CMD_READ) begin
			result.rdata = word_access ? read_word : {8'd0, read_word[7:0]};
		end
		result.sys_reset_out = pulse_on && (as_reset || control_d[CTL_RESET]);
		result.smi_out       = pulse_on && !as_reset && control_d[CTL_SMI];
		result.nmi_out       = pulse_on && !as_reset && control_d[CTL_NMI];
		result.sci_out       = pulse_on && !as_reset && control_d[CTL_SCI];
	end

	// state registers, updated once per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_index_q    <= 8'd0;
			control_q      <= 16'd0;
			status_q       <= 8'd0;
			reload1_q      <= 16'hFFFF;
			count1_q       <= 16'hFFFF;
			reload2_q      <= 8'hFF;
			count2_q       <= 8'hFF;
			running2_q     <= 1'b0;
			pulse_length_q <= 8'hFF;
			pulse_left_q   <= 8'd0;
		end else if (accept) begin
			reg_index_q    <= reg_index_d;
			control_q      <= control_d;
			status_q       <= status_d;
			reload1_q      <= reload1_d;
			count1_q       <= count1_d;
			reload2_q      <= reload2_d;
			count2_q       <= count2_d;
			running2_q     <= running2_d;
			pulse_length_q <= pulse_length_d;
			pulse_left_q   <= pulse_left_d;
		end
	end

	// a read leaves the watchdog state alone
	a_read_no_side_effect: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd_e == CMD_READ |=> $stable(count1_q) && $stable(count2_q)
			&& $stable(status_q) && $stable(running2_q) && $stable(pulse_left_q))
		else $error("read transaction changed watchdog state");

	// index write lands in the index register
	a_index_write: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd_e == CMD_INDEX |=> reg_index_q == $past(wdata[7:0]))
		else $error("index register not loaded");

	// stage-one expiry starts stage two and flags status
	a_stage1_expiry: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd_e == CMD_TICK && control_q[CTL_EN1] && !running2_q
			&& count1_q <= 16'd1
		|=> running2_q && status_q[ST_EXP1] && !status_q[ST_EXP2]
			&& count1_q == reload1_q)
		else $error("stage one expiry not handled");

	// stage two never counts while stopped, apart from the reload on stage-one expiry
	a_stage2_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd_e == CMD_TICK && !running2_q
			&& !(control_q[CTL_EN1] && count1_q <= 16'd1)
		|=> $stable(count2_q))
		else $error("stage two counted while stopped");

endmodule

// File: design/two_stage_watchdog_registers.sv
// Two-stage watchdog behind an index/data register port. Each request
// transaction is one of: a 32 kHz tick, an index write, a data write or a data
// read; each produces exactly one response carrying the read data (zero unless
// a read) and the four pulse outputs as they stand after that transaction. The
// state update and the response are computed in one pass of logic from the
// state registers and land in the response register at the accepting edge, so
// one transaction is taken every cycle as long as the response side keeps up;
// the single response register lets the next request in during the cycle its
// result is being taken.
module two_stage_watchdog_registers
	import tswd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	tswd_req_if.sink      req,
	tswd_rsp_if.source    rsp
);

	logic         req_accept;
	logic         rsp_valid_q;
	tswd_result_t next_result;
	tswd_result_t result_q;

	// a new request enters whenever the response register is empty or draining
	assign req.ready  = !rsp_valid_q || rsp.ready;
	assign req_accept = req.valid && req.ready;

	tswd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (req_accept),
		.cmd         (req.cmd),
		.word_access (req.word_access),
		.wdata       (req.wdata),
		.result      (next_result)
	);

	// response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (req_accept) begin
			result_q <= next_result;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.rdata         = result_q.rdata;
	assign rsp.sys_reset_out = result_q.sys_reset_out;
	assign rsp.smi_out       = result_q.smi_out;
	assign rsp.nmi_out       = result_q.nmi_out;
	assign rsp.sci_out       = result_q.sci_out;

	// every accepted request yields a response in the next cycle
	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_accept |=> rsp_valid_q)
		else $error("accepted transaction produced no response");

	// a taken response with no new request empties the register
	a_resp_drains: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp.ready && !req_accept |=> !rsp_valid_q)
		else $error("response repeated");

	// no request taken while a stalled response is held
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |-> !req_accept)
		else $error("request accepted over a stalled response");

endmodule

// File: dv/two_stage_watchdog_registers_checker.sv
module two_stage_watchdog_registers_checker
	import tswd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tswd_req_if  req,
	tswd_rsp_if  rsp,
	output int   mismatches,
	output int   outstanding
);

	// watchdog state as the block should hold it
	logic [7:0]  sel_index;
	logic [15:0] ctl_word;
	logic [7:0]  status_reg;
	logic [15:0] s1_reload;
	logic [15:0] s1_count;
	logic [7:0]  s2_reload;
	logic [7:0]  s2_count;
	logic        s2_running;
	logic [7:0]  pulse_ticks;
	logic [7:0]  pulse_left;

	tswd_result_t pending_results[$];
	tswd_result_t predicted;
	tswd_result_t seen;
	int           rsp_seq;
	int           fail_count = 0;

	assign mismatches = fail_count;

	task automatic report_mismatch(input string what, input logic [15:0] want,
		input logic [15:0] got);
		$display("mismatch in response %0d, %s: expected %h, got %h",
			rsp_seq, what, want, got);
		fail_count++;
	endtask

	// one 32 kHz tick: pulse countdown, then stage one, then stage two
	task automatic advance_tick();
		bit stage1_fired;
		stage1_fired = 1'b0;
		if (pulse_left != 8'd0)
			pulse_left--;
		if (ctl_word[CTL_EN1] && !s2_running) begin
			if (s1_count != 16'd0)
				s1_count--;
			if (s1_count == 16'd0) begin
				status_reg[ST_EXP2] = 1'b0;
				status_reg[ST_EXP1] = 1'b1;
				s1_count = s1_reload;
				s2_count = s2_reload;
				s2_running = 1'b1;
				pulse_left = pulse_ticks;
				stage1_fired = 1'b1;
			end
		end
		if (!stage1_fired && s2_running && (ctl_word[CTL_EN1] || ctl_word[CTL_EN2])) begin
			if (s2_count != 8'd0)
				s2_count--;
			if (s2_count == 8'd0) begin
				s2_running = 1'b0;
				status_reg[ST_EXP2] = 1'b1;
				pulse_left = pulse_ticks;
			end
		end
	endtask

	// data port write to the selected register
	task automatic write_selected(input logic word, input logic [15:0] wd);
		logic [15:0] merged;
		logic [15:0] rising;
		case (sel_index)
			IDX_COUNT1: begin
				s1_reload = word ? wd : {s1_reload[15:8], wd[7:0]};
				s1_count = s1_reload;
			end
			IDX_COUNT2: begin
				s2_reload = wd[7:0];
				s2_count = s2_reload;
			end
			IDX_PULSE: begin
				pulse_ticks = wd[7:0];
			end
			IDX_CONTROL: begin
				merged = word ? wd : {ctl_word[15:8], wd[7:0]};
				rising = merged & ~ctl_word;
				ctl_word = merged;
				if (rising[CTL_RST1]) begin
					s1_count = s1_reload;
					s2_running = 1'b0;
				end
				if (rising[CTL_RST2])
					s2_count = s2_reload;
			end
			IDX_STATUS: begin
				status_reg = wd[7:0];
			end
			default: ;
		endcase
	endtask

	// data port read of the selected register
	function automatic logic [15:0] read_selected(input logic word);
		logic [15:0] value;
		case (sel_index)
			IDX_VERSION: value = VERSION_WORD;
			IDX_COUNT1:  value = s1_count;
			IDX_COUNT2:  value = {8'd0, s2_count};
			IDX_PULSE:   value = {8'd0, pulse_ticks};
			IDX_CONTROL: value = ctl_word;
			IDX_STATUS:  value = {8'd0, status_reg};
			default:     value = 16'd0;
		endcase
		return word ? value : {8'd0, value[7:0]};
	endfunction

	// apply one request transaction and work out its response
	task automatic step_watchdog(input tswd_cmd_t op, input logic word,
		input logic [15:0] wd, output tswd_result_t res);
		logic pulsing;
		logic as_reset;
		res.rdata = 16'd0;
		case (op)
			CMD_TICK:  advance_tick();
			CMD_INDEX: sel_index = wd[7:0];
			CMD_WRITE: write_selected(word, wd);
			CMD_READ:  res.rdata = read_selected(word);
			default: ;
		endcase
		pulsing = pulse_left != 8'd0;
		as_reset = status_reg[ST_EXP2];
		res.sys_reset_out = pulsing && (as_reset || ctl_word[CTL_RESET]);
		res.smi_out = pulsing && !as_reset && ctl_word[CTL_SMI];
		res.nmi_out = pulsing && !as_reset && ctl_word[CTL_NMI];
		res.sci_out = pulsing && !as_reset && ctl_word[CTL_SCI];
	endtask

	// compare responses in order, then queue the prediction for any new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_index = 8'd0;
			ctl_word = 16'd0;
			status_reg = 8'd0;
			s1_reload = 16'hFFFF;
			s1_count = 16'hFFFF;
			s2_reload = 8'hFF;
			s2_count = 8'hFF;
			s2_running = 1'b0;
			pulse_ticks = 8'hFF;
			pulse_left = 8'd0;
			pending_results.delete();
			rsp_seq = 0;
			outstanding = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen.rdata = rsp.rdata;
				seen.sys_reset_out = rsp.sys_reset_out;
				seen.smi_out = rsp.smi_out;
				seen.nmi_out = rsp.nmi_out;
				seen.sci_out = rsp.sci_out;
				if (pending_results.size() == 0) begin
					report_mismatch("response with no request waiting", 16'd0, seen.rdata);
				end else begin
					predicted = pending_results.pop_front();
					if (seen.rdata !== predicted.rdata)
						report_mismatch("rdata", predicted.rdata, seen.rdata);
					if (seen.sys_reset_out !== predicted.sys_reset_out)
						report_mismatch("sys_reset_out", 16'(predicted.sys_reset_out),
							16'(seen.sys_reset_out));
					if (seen.smi_out !== predicted.smi_out)
						report_mismatch("smi_out", 16'(predicted.smi_out), 16'(seen.smi_out));
					if (seen.nmi_out !== predicted.nmi_out)
						report_mismatch("nmi_out", 16'(predicted.nmi_out), 16'(seen.nmi_out));
					if (seen.sci_out !== predicted.sci_out)
						report_mismatch("sci_out", 16'(predicted.sci_out), 16'(seen.sci_out));
				end
				rsp_seq++;
			end
			if (req.valid && req.ready) begin
				step_watchdog(tswd_cmd_t'(req.cmd), req.word_access, req.wdata, predicted);
				pending_results.push_back(predicted);
			end
			outstanding = pending_results.size();
		end
	end

endmodule

// File: dv/two_stage_watchdog_registers_test.sv
module two_stage_watchdog_registers_test;
	import tswd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tswd_req_if req_bus();
	tswd_rsp_if rsp_bus();

	int mismatches;
	int outstanding;
	int useful_items;
	bit quiet_run;

	logic [7:0] reg_map [6] = '{IDX_VERSION, IDX_COUNT1, IDX_COUNT2, IDX_PULSE,
		IDX_CONTROL, IDX_STATUS};

	two_stage_watchdog_registers DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus.sink),
		.rsp    (rsp_bus.source)
	);

	two_stage_watchdog_registers_checker watchdog_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_bus),
		.rsp         (rsp_bus),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// overall time limit
	initial begin
		#(12 * 500000);
		$display("TEST FAILED");
		$finish;
	end

	// idle length between request transactions: mostly none, a few long
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_run || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 20);
	endfunction

	// offer one request transaction and wait until it is taken
	task automatic send_item(input tswd_cmd_t op, input logic word, input logic [15:0] wd,
		input bit counted = 1'b1);
		int gap;
		req_bus.valid <= 1'b1;
		req_bus.cmd <= op;
		req_bus.word_access <= word;
		req_bus.wdata <= wd;
		do @(posedge clk); while (!req_bus.ready);
		if (counted)
			useful_items++;
		gap = idle_cycles();
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic set_reg(input logic [7:0] idx, input logic [15:0] wd, input logic word);
		send_item(CMD_INDEX, 1'($urandom), {8'($urandom), idx});
		send_item(CMD_WRITE, word, wd);
	endtask

	// read a register, sometimes reusing the index already selected
	task automatic read_some_reg();
		logic [7:0] idx;
		idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : reg_map[$urandom_range(0, 5)];
		if ($urandom_range(0, 3) != 0)
			send_item(CMD_INDEX, 1'($urandom), {8'($urandom), idx});
		send_item(CMD_READ, 1'($urandom), 16'($urandom));
	endtask

	// load both stages, the pulse length and the control word
	task automatic program_watchdog();
		int r;
		logic [15:0] count1;
		logic [7:0] count2;
		logic [7:0] plen;
		logic [15:0] ctl;
		r = $urandom_range(0, 19);
		count1 = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'($urandom) :
			16'($urandom_range(1, 12));
		set_reg(IDX_COUNT1, count1, $urandom_range(0, 7) != 0);
		r = $urandom_range(0, 19);
		count2 = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(1, 6));
		set_reg(IDX_COUNT2, {8'($urandom), count2}, 1'($urandom));
		r = $urandom_range(0, 19);
		plen = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(1, 4));
		set_reg(IDX_PULSE, {8'($urandom), plen}, 1'($urandom));
		ctl = 16'd0;
		ctl[CTL_EN1] = $urandom_range(0, 4) != 0;
		ctl[CTL_EN2] = 1'($urandom);
		ctl[CTL_RST1] = 1'($urandom);
		ctl[CTL_RST2] = 1'($urandom);
		ctl[CTL_SCI] = 1'($urandom);
		ctl[CTL_NMI] = 1'($urandom);
		ctl[CTL_SMI] = 1'($urandom);
		ctl[CTL_RESET] = 1'($urandom);
		if ($urandom_range(0, 7) == 0)
			ctl = 16'($urandom);
		set_reg(IDX_CONTROL, ctl, $urandom_range(0, 5) != 0);
	endtask

	// run of ticks with the odd read in between
	task automatic tick_burst();
		int n;
		n = $urandom_range(1, 30);
		repeat (n) begin
			if ($urandom_range(0, 5) == 0)
				read_some_reg();
			else
				send_item(CMD_TICK, 1'($urandom), 16'($urandom));
		end
	endtask

	// drop then raise the stage reset bits to reload the counters
	task automatic restart_stages();
		logic [15:0] ctl;
		ctl = 16'($urandom) & ~(16'(1) << CTL_RST1) & ~(16'(1) << CTL_RST2);
		ctl[CTL_EN1] = $urandom_range(0, 3) != 0;
		set_reg(IDX_CONTROL, ctl, 1'b1);
		ctl[CTL_RST1] = 1'($urandom);
		ctl[CTL_RST2] = !ctl[CTL_RST1] || 1'($urandom);
		send_item(CMD_WRITE, 1'($urandom), ctl);
	endtask

	// response side: mostly ready, with short and long stalls
	initial begin
		int r;
		int span;
		rsp_bus.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		rsp_bus.ready <= 1'b1;
		repeat (30) @(posedge clk);
		// long hold-off so that the block backs up onto its request side
		rsp_bus.ready <= 1'b0;
		repeat (60) @(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				rsp_bus.ready <= 1'b1;
				span = $urandom_range(1, 12);
			end else if (r < 90) begin
				rsp_bus.ready <= 1'b0;
				span = $urandom_range(1, 3);
			end else if (r < 97) begin
				rsp_bus.ready <= 1'b0;
				span = $urandom_range(5, 25);
			end else begin
				rsp_bus.ready <= 1'b1;
				span = $urandom_range(30, 80);
			end
			repeat (span) @(posedge clk);
		end
	end

	// stimulus and verdict
	initial begin
		int pick;
		req_bus.valid <= 1'b0;
		req_bus.cmd <= CMD_TICK;
		req_bus.word_access <= 1'b0;
		req_bus.wdata <= 16'd0;
		useful_items = 0;
		quiet_run = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unknown index, version word, zero stage-one count expiry,
		// action pulse then system reset pulse, byte write with reset edges,
		// sticky status, zero pulse length, index taken from the low byte
		send_item(CMD_READ, 1'b1, 16'hFFFF);
		send_item(CMD_INDEX, 1'b0, {8'h00, IDX_VERSION});
		send_item(CMD_READ, 1'b1, 16'h0000);
		send_item(CMD_READ, 1'b0, 16'h0000);
		send_item(CMD_WRITE, 1'b1, 16'h1234);
		set_reg(IDX_COUNT1, 16'h0000, 1'b1);
		set_reg(IDX_COUNT2, 16'h0002, 1'b1);
		set_reg(IDX_PULSE, 16'h0001, 1'b0);
		set_reg(IDX_CONTROL, 16'h0F01, 1'b1);
		repeat (3) send_item(CMD_TICK, 1'b0, 16'h0000);
		send_item(CMD_WRITE, 1'b0, 16'hFF30);
		send_item(CMD_INDEX, 1'b1, {8'hFF, IDX_STATUS});
		send_item(CMD_READ, 1'b0, 16'h0000);
		send_item(CMD_WRITE, 1'b1, 16'hFFFF);
		send_item(CMD_INDEX, 1'b0, {8'h55, IDX_PULSE});
		send_item(CMD_WRITE, 1'b1, 16'h0000);
		send_item(CMD_INDEX, 1'b0, {8'hAB, IDX_CONTROL});
		send_item(CMD_WRITE, 1'b1, 16'hFFFF);
		repeat (2) send_item(CMD_TICK, 1'b1, 16'hFFFF);

		// random: mostly well-formed programming and tick runs, some noise
		while (useful_items < 1150) begin
			quiet_run = $urandom_range(0, 3) == 0;
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				program_watchdog();
			end else if (pick < 60) begin
				tick_burst();
			end else if (pick < 70) begin
				restart_stages();
			end else if (pick < 78) begin
				set_reg(IDX_STATUS, 16'($urandom), 1'($urandom));
			end else if (pick < 85) begin
				read_some_reg();
			end else begin
				repeat ($urandom_range(1, 4))
					send_item(tswd_cmd_t'($urandom_range(0, 3)), 1'($urandom),
						16'($urandom), 1'b0);
			end
		end
		req_bus.valid <= 1'b0;

		// drain outstanding responses, then let the pipeline settle
		do @(posedge clk); while (outstanding != 0);
		repeat (5) @(posedge clk);
		if (outstanding != 0)
			$display("%0d responses never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
